>>> design/mst_pkg.sv
// shared types and constants of the minimum spanning tree engine
`default_nettype none

package mst_pkg;

   localparam int VTX_W     = 4;
   localparam int WGT_W     = 8;
   localparam int CNT_REG_W = 5;
   localparam int DATA_W    = 16;

   localparam logic [WGT_W-1:0]     NO_EDGE      = 8'hFF;
   localparam logic [CNT_REG_W-1:0] VCOUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      REQ_SET_EDGE = 2'd0,
      REQ_RUN      = 2'd1,
      REQ_CLEAR    = 2'd2
   } req_kind_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WR_AB = 6'b000010,
      ST_WR_BA = 6'b000100,
      ST_ROW   = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

>>> design/minimum_spanning_tree_engine_unit.sv
// prim minimum spanning tree engine over a stored adjacency matrix
`default_nettype none

//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------------
//  req_      | in  | req_tvalid/req_tready | tuser: request kind, tdata: a, b, weight
//  rsp_      | out | rsp_tvalid/rsp_tready | tdata: from, to, weight, tlast: final edge
//  csr_      | in  | csr_wen               | csr_wdata: vertex count
//
//  set edge is accepted and then writes the matrix once per direction; clear acts at accept
//  a run of n vertices is paced by the single matrix read port walking one row entry per
//  cycle and by the one-entry-a-cycle scan
//  reset is synchronous; entry valid bits make the matrix read as no edge at once, no sweep
//  req_tready is high only while the sequencer is idle; a stalled result holds the
//  sequencer in its emit step until the output register frees up

module minimum_spanning_tree_engine_unit
   import mst_pkg::*;
#(
   parameter int MAX_VERTICES = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   // request transaction
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire [DATA_W-1:0]     req_tdata,   // vertex_a[3:0], vertex_b[7:4], edge_weight[15:8]
   input  wire [1:0]            req_tuser,   // req_type[1:0]
   // result transaction
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // from_vertex[3:0], to_vertex[7:4], tree_weight[15:8]
   output logic                 rsp_tlast,   // last
   // vertex count register
   input  wire                  csr_wen,
   input  wire [CNT_REG_W-1:0]  csr_wdata
);

   // vertices actually addressable: fields are four bits wide
   localparam int VCAP    = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int VIDX_W  = $clog2(VCAP);
   localparam int VCNT_W  = $clog2(VCAP + 1);
   localparam int ENTRIES = VCAP * VCAP;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam logic [CNT_REG_W-1:0] VCAP_REG = CNT_REG_W'(VCAP);

   function automatic logic [ADDR_W-1:0] mat_addr(input logic [VIDX_W-1:0] row,
                                                  input logic [VIDX_W-1:0] col);
      mat_addr = ADDR_W'(row) * ADDR_W'(VCAP) + ADDR_W'(col);
   endfunction

   // request fields
   logic [VTX_W-1:0] req_a;
   logic [VTX_W-1:0] req_b;
   logic [WGT_W-1:0] req_w;
   req_kind_type     req_kind;

   assign req_a    = req_tdata[3:0];
   assign req_b    = req_tdata[7:4];
   assign req_w    = req_tdata[15:8];
   assign req_kind = req_kind_type'(req_tuser);

   // sequencer registers
   state_type             state_ff,  state_in;
   logic [CNT_REG_W-1:0]  vcount_ff, vcount_in;
   logic [VCNT_W-1:0]     n_ff,      n_in;
   logic [VIDX_W-1:0]     a_ff,      a_in;
   logic [VIDX_W-1:0]     b_ff,      b_in;
   logic [WGT_W-1:0]      w_ff,      w_in;
   logic [VIDX_W-1:0]     k_ff,      k_in;       // vertex being added / relaxing from
   logic [WGT_W-1:0]      bestc_ff,  bestc_in;   // cheapest cost seen in the scan
   logic                  found_ff,  found_in;
   logic [VCNT_W-1:0]     idx_ff,    idx_in;     // scan / row walk position
   logic [VCNT_W-1:0]     added_ff,  added_in;   // vertices already in the tree
   logic                  force_ff,  force_in;   // first row pass loads costs outright
   logic                  pend_ff,   pend_in;    // a matrix read is returning
   logic [VIDX_W-1:0]     pidx_ff,   pidx_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0]     rsp_data_ff,   rsp_data_in;
   logic                  rsp_last_ff,   rsp_last_in;

   // matrix store and its entry valid bits
   logic [WGT_W-1:0]   adj_mem [ENTRIES];
   logic [ENTRIES-1:0] adj_valid_ff;
   logic [WGT_W-1:0]   rd_data_ff;
   logic               rd_valid_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic               valid_clear;

   // per-vertex run state
   logic [WGT_W-1:0]  cost_ff   [VCAP];
   logic [VIDX_W-1:0] parent_ff [VCAP];
   logic [VCAP-1:0]   in_tree_ff;
   logic              tree_init;
   logic              tree_set;

   // relaxation stage on returning row data
   logic [WGT_W-1:0]  relax_w;
   logic              relax_upd;
   logic [VIDX_W-1:0] cost_rd_idx;
   logic [WGT_W-1:0]  cost_rd;
   logic [VCNT_W-1:0] added_plus;
   logic              is_last;
   logic              emit_fire;
   logic [VCNT_W-1:0] run_n;

   assign cost_rd_idx = (state_ff == ST_SCAN) ? idx_ff[VIDX_W-1:0] : pidx_ff;
   assign cost_rd     = cost_ff[cost_rd_idx];
   assign relax_w     = rd_valid_ff ? rd_data_ff : NO_EDGE;
   assign relax_upd   = pend_ff &&
                        (force_ff || (!in_tree_ff[pidx_ff] && (relax_w < cost_rd)));
   assign added_plus  = added_ff + VCNT_W'(1);
   assign is_last     = (added_plus == n_ff);
   assign emit_fire   = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   // vertex count in use: zero acts as one, large values saturate
   always_comb begin
      if (vcount_ff == '0) begin
         run_n = VCNT_W'(1);
      end else if (vcount_ff > VCAP_REG) begin
         run_n = VCNT_W'(VCAP);
      end else begin
         run_n = VCNT_W'(vcount_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      vcount_in     = csr_wen ? csr_wdata : vcount_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      k_in          = k_ff;
      bestc_in      = bestc_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      added_in      = added_ff;
      force_in      = force_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = mat_addr(a_ff, b_ff);
      mem_re        = 1'b0;
      mem_raddr     = mat_addr(k_ff, idx_ff[VIDX_W-1:0]);
      valid_clear   = 1'b0;
      tree_init     = 1'b0;
      tree_set      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  REQ_SET_EDGE: begin
                     a_in = req_a[VIDX_W-1:0];
                     b_in = req_b[VIDX_W-1:0];
                     w_in = req_w;
                     // endpoints past the matrix are dropped
                     if (({1'b0, req_a} < VCAP_REG) && ({1'b0, req_b} < VCAP_REG)) begin
                        state_in = ST_WR_AB;
                     end
                  end
                  REQ_RUN: begin
                     n_in      = run_n;
                     k_in      = '0;
                     force_in  = 1'b1;
                     idx_in    = VCNT_W'(1);
                     pend_in   = 1'b0;
                     added_in  = VCNT_W'(1);
                     tree_init = 1'b1;
                     state_in  = ST_ROW;
                  end
                  REQ_CLEAR: begin
                     valid_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WR_AB: begin
            mem_we    = 1'b1;
            mem_waddr = mat_addr(a_ff, b_ff);
            state_in  = ST_WR_BA;
         end
         ST_WR_BA: begin
            mem_we    = 1'b1;
            mem_waddr = mat_addr(b_ff, a_ff);
            state_in  = ST_IDLE;
         end
         ST_ROW: begin
            if (idx_ff < n_ff) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               pidx_in = idx_ff[VIDX_W-1:0];
               idx_in  = idx_ff + VCNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  idx_in   = VCNT_W'(1);
                  found_in = 1'b0;
                  state_in = (added_ff == n_ff) ? ST_IDLE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < n_ff) begin
               if (!in_tree_ff[idx_ff[VIDX_W-1:0]] && (!found_ff || (cost_rd < bestc_ff))) begin
                  k_in     = idx_ff[VIDX_W-1:0];
                  bestc_in = cost_rd;
                  found_in = 1'b1;
               end
               idx_in = idx_ff + VCNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {bestc_ff, VTX_W'(k_ff), VTX_W'(parent_ff[k_ff])};
               rsp_last_in   = is_last;
               tree_set      = 1'b1;
               added_in      = added_plus;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = VCNT_W'(1);
                  force_in = 1'b0;
                  pend_in  = 1'b0;
                  state_in = ST_ROW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= VCOUNT_RESET;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      w_ff        <= w_in;
      k_ff        <= k_in;
      bestc_ff    <= bestc_in;
      idx_ff      <= idx_in;
      added_ff    <= added_in;
      force_ff    <= force_in;
      pidx_ff     <= pidx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // matrix memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_mem[mem_waddr] <= w_ff;
      end
      if (mem_re) begin
         rd_data_ff <= adj_mem[mem_raddr];
      end
   end

   // an entry never written since reset or clear reads as no edge
   always_ff @(posedge clock) begin
      if (reset || valid_clear) begin
         adj_valid_ff <= '0;
      end else if (mem_we) begin
         adj_valid_ff[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
         rd_valid_ff <= adj_valid_ff[mem_raddr] && !(reset || valid_clear);
      end
   end

   // tree membership and best links
   always_ff @(posedge clock) begin
      if (tree_init) begin
         in_tree_ff <= VCAP'(1);
      end else if (tree_set) begin
         in_tree_ff[k_ff] <= 1'b1;
      end
      if (relax_upd) begin
         cost_ff[pidx_ff]   <= relax_w;
         parent_ff[pidx_ff] <= k_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a finished scan always has an unattached vertex to pick
   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && idx_ff == n_ff) |-> found_ff)
      else $error("scan ended without a candidate");

   // row data only returns during a row walk
   a_pend_in_row: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_ROW))
      else $error("matrix read pending outside row walk");

   // scanning only while vertices remain outside the tree
   a_scan_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (added_ff < n_ff))
      else $error("scan with tree already complete");

   // an emit step loads the output register
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> rsp_tvalid)
      else $error("emitted edge not presented");

endmodule

`default_nettype wire
